// File: rtl/core/rths_pkg.sv
// Shared types and constants for the RGB to hue/saturation pipeline.
// No dependencies; every other file in rtl/core uses it.
`default_nettype none

package rths_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned HueW   = 9;
  localparam int unsigned SatW   = 7;
  // Both quotients stay below 128, so seven restoring steps cover them.
  localparam int unsigned QuotW  = 7;
  // Widest numerator is 100 * 255 = 25500.
  localparam int unsigned RemW   = 15;

  localparam int unsigned HueSector = 60;
  localparam int unsigned HueFull   = 360;
  localparam int unsigned HueGreen  = 120;
  localparam int unsigned HueBlue   = 240;
  localparam int unsigned PctScale  = 100;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [HueW-1:0]  hue_off;
    logic             hue_neg;
    logic [ChanW-1:0] hue_den;
    logic [RemW-1:0]  hue_rem;
    logic [QuotW-1:0] hue_quot;
    logic [ChanW-1:0] sat_den;
    logic [RemW-1:0]  sat_rem;
    logic [QuotW-1:0] sat_quot;
  } rths_pipe_t;

endpackage

`default_nettype wire

// File: rtl/core/rths_prep.sv
// First pipeline stage: max/min search, sector selection and numerators.
// Depends on rths_pkg.
`default_nettype none

module rths_prep (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           ready_o,
  input  wire logic [rths_pkg::ChanW-1:0] red_i,
  input  wire logic [rths_pkg::ChanW-1:0] green_i,
  input  wire logic [rths_pkg::ChanW-1:0] blue_i,
  output logic                           valid_o,
  input  wire logic                      ready_i,
  output rths_pkg::rths_pipe_t           data_o
);

  logic                 valid_q;
  rths_pkg::rths_pipe_t data_q, data_d;

  logic [rths_pkg::ChanW-1:0] mx, mn, delta, pos, negv;
  logic                       neg;
  logic [rths_pkg::HueW-1:0]  off;

  always_comb begin
    // Red wins ties, then green.
    if (red_i >= green_i && red_i >= blue_i) begin
      mx   = red_i;
      pos  = green_i;
      negv = blue_i;
      off  = rths_pkg::HueW'(rths_pkg::HueFull);
    end else if (green_i >= blue_i) begin
      mx   = green_i;
      pos  = blue_i;
      negv = red_i;
      off  = rths_pkg::HueW'(rths_pkg::HueGreen);
    end else begin
      mx   = blue_i;
      pos  = red_i;
      negv = green_i;
      off  = rths_pkg::HueW'(rths_pkg::HueBlue);
    end
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;
    neg   = (pos < negv);

    data_d          = '0;
    data_d.red      = red_i;
    data_d.green    = green_i;
    data_d.blue     = blue_i;
    data_d.hue_off  = off;
    data_d.hue_neg  = neg;
    data_d.hue_den  = delta;
    // The divider works on the magnitude; the floor is fixed up at the end.
    data_d.hue_rem  = rths_pkg::RemW'(neg ? (negv - pos) : (pos - negv))
                      * rths_pkg::RemW'(rths_pkg::HueSector);
    data_d.sat_den  = mx;
    data_d.sat_rem  = rths_pkg::RemW'(delta) * rths_pkg::RemW'(rths_pkg::PctScale);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/core/rths_div_step.sv
// One restoring division step for both the hue and the saturation quotient.
// Depends on rths_pkg; BitIdx selects which quotient bit this stage settles.
`default_nettype none

module rths_div_step #(
  parameter int unsigned BitIdx = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire rths_pkg::rths_pipe_t data_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output rths_pkg::rths_pipe_t      data_o
);

  logic                          valid_q;
  rths_pkg::rths_pipe_t          data_q, data_d;
  logic [rths_pkg::RemW-1:0]     hue_dsh, sat_dsh;

  assign hue_dsh = rths_pkg::RemW'(data_i.hue_den) << BitIdx;
  assign sat_dsh = rths_pkg::RemW'(data_i.sat_den) << BitIdx;

  always_comb begin
    data_d = data_i;
    if (data_i.hue_rem >= hue_dsh) begin
      data_d.hue_rem          = data_i.hue_rem - hue_dsh;
      data_d.hue_quot[BitIdx] = 1'b1;
    end
    if (data_i.sat_rem >= sat_dsh) begin
      data_d.sat_rem          = data_i.sat_rem - sat_dsh;
      data_d.sat_quot[BitIdx] = 1'b1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/core/rths_post.sv
// Last stage: floor correction, offset and wrap of the hue, special cases.
// Depends on rths_pkg. Its register is the block's output register.
`default_nettype none

module rths_post (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire rths_pkg::rths_pipe_t       data_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output logic [rths_pkg::HueW-1:0]       hue_o,
  output logic [rths_pkg::SatW-1:0]       sat_o,
  output logic [rths_pkg::ChanW-1:0]      red_o,
  output logic [rths_pkg::ChanW-1:0]      green_o,
  output logic [rths_pkg::ChanW-1:0]      blue_o
);

  localparam int unsigned SumW = rths_pkg::HueW + 1;

  logic                         valid_q;
  logic [rths_pkg::HueW-1:0]    hue_q, hue_d;
  logic [rths_pkg::SatW-1:0]    sat_q, sat_d;
  logic [rths_pkg::ChanW-1:0]   red_q, green_q, blue_q;
  logic [rths_pkg::QuotW-1:0]   q_ceil;
  logic [SumW-1:0]              sum;

  always_comb begin
    // A negative difference must round toward minus infinity.
    q_ceil = data_i.hue_quot + rths_pkg::QuotW'(data_i.hue_rem != '0);
    if (data_i.hue_neg) begin
      sum = SumW'(data_i.hue_off) - SumW'(q_ceil);
    end else begin
      sum = SumW'(data_i.hue_off) + SumW'(data_i.hue_quot);
    end
    if (sum >= SumW'(rths_pkg::HueFull)) begin
      sum = sum - SumW'(rths_pkg::HueFull);
    end
    hue_d = (data_i.hue_den == '0) ? '0 : sum[rths_pkg::HueW-1:0];
    sat_d = (data_i.sat_den == '0) ? '0 : data_i.sat_quot[rths_pkg::SatW-1:0];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      red_q   <= data_i.red;
      green_q <= data_i.green;
      blue_q  <= data_i.blue;
    end
  end

  assign valid_o = valid_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire

// File: rtl/core/rgb_to_hue_saturation_top.sv
// RGB pixel to hue (whole degrees) and saturation (percent) converter.
// Pipeline: 1 prep stage, 7 divider stages that each settle one quotient bit
// of both dividers, and 1 output stage, each ending in its own register.
// Throughput: one pixel per cycle while the output is not stalled; each stage holds its transaction on a stall.
// Reset: asynchronous, active low; clears all stage valid bits.
`default_nettype none

module rgb_to_hue_saturation_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [rths_pkg::ChanW-1:0]  red_i,
  input  wire logic [rths_pkg::ChanW-1:0]  green_i,
  input  wire logic [rths_pkg::ChanW-1:0]  blue_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [rths_pkg::HueW-1:0]        hue_degrees_o,
  output logic [rths_pkg::SatW-1:0]        saturation_pct_o,
  output logic [rths_pkg::ChanW-1:0]       red_echo_o,
  output logic [rths_pkg::ChanW-1:0]       green_echo_o,
  output logic [rths_pkg::ChanW-1:0]       blue_echo_o
);

  localparam int unsigned Steps = rths_pkg::QuotW;

  logic                 st_valid [Steps+1];
  logic                 st_ready [Steps+1];
  rths_pkg::rths_pipe_t st_data  [Steps+1];

  rths_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (st_valid[0]),
    .ready_i (st_ready[0]),
    .data_o  (st_data[0])
  );

  // Most significant quotient bit first.
  for (genvar k = 0; k < Steps; k++) begin : g_div
    rths_div_step #(
      .BitIdx (Steps - 1 - k)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[k]),
      .ready_o (st_ready[k]),
      .data_i  (st_data[k]),
      .valid_o (st_valid[k+1]),
      .ready_i (st_ready[k+1]),
      .data_o  (st_data[k+1])
    );
  end

  rths_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st_valid[Steps]),
    .ready_o (st_ready[Steps]),
    .data_i  (st_data[Steps]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .hue_o   (hue_degrees_o),
    .sat_o   (saturation_pct_o),
    .red_o   (red_echo_o),
    .green_o (green_echo_o),
    .blue_o  (blue_echo_o)
  );

endmodule

`default_nettype wire
